// ----- rtl/csv_field_delimiter_converter_assert.svh -----
// Assertion macros for the CSV field converter.
// Each use expands to a complete statement; write it without a trailing semicolon.
`ifndef CSV_FIELD_DELIMITER_CONVERTER_ASSERT_SVH
`define CSV_FIELD_DELIMITER_CONVERTER_ASSERT_SVH
`ifndef SYNTHESIS
// Condition that must hold at every clock edge outside reset.
`define CSVFD_ASSERT(label, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);
// Condition that must hold in the cycle after the trigger.
`define CSVFD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define CSVFD_ASSERT(label, expr, msg)
`define CSVFD_ASSERT_NEXT(label, ante, cons, msg)
`endif
`endif

// ----- rtl/csvfd_pkg.sv -----
package csvfd_pkg;

    localparam int LINE_NUMBER_BITS = 16;
    localparam int TARGET_BITS      = 16;
    localparam int CMP_BITS = (LINE_NUMBER_BITS > TARGET_BITS) ? LINE_NUMBER_BITS : TARGET_BITS;

    // register indexes
    localparam logic [1:0] REG_MODE          = 2'd0;
    localparam logic [1:0] REG_TARGET_LINE   = 2'd1;
    localparam logic [1:0] REG_OUT_SEPARATOR = 2'd2;
    localparam logic [1:0] REG_IN_SEPARATOR  = 2'd3;

    // mode codes; the unused code behaves as convert
    localparam logic [1:0] MODE_CONVERT = 2'd0;
    localparam logic [1:0] MODE_DELETE  = 2'd1;
    localparam logic [1:0] MODE_KEEP    = 2'd2;

    localparam logic [7:0] BYTE_NL    = 8'd10;
    localparam logic [7:0] BYTE_QUOTE = 8'd34;

    localparam logic [7:0] OUT_SEPARATOR_RESET = 8'd124;
    localparam logic [7:0] IN_SEPARATOR_RESET  = 8'd44;

    typedef enum logic [1:0] {
        PH_START  = 2'd0,
        PH_PLAIN  = 2'd1,
        PH_QUOTED = 2'd2,
        PH_CLOSED = 2'd3
    } phase_t;

    typedef struct packed {
        logic [1:0]  mode;
        logic [15:0] target_line;
        logic [7:0]  out_separator;
        logic [7:0]  in_separator;
    } cfg_t;

    typedef struct packed {
        phase_t                      phase;
        logic [LINE_NUMBER_BITS-1:0] line_number;
        logic                        keep_done;
    } parse_state_t;

    // up to two output words per input word, head goes out first
    typedef struct packed {
        logic [1:0] count;
        logic [7:0] head;
        logic [7:0] tail;
    } result_t;

endpackage

// ----- rtl/csvfd_step.sv -----
module csvfd_step (
    input  logic [7:0]              in_byte,
    input  csvfd_pkg::cfg_t         cfg,
    input  csvfd_pkg::parse_state_t state,
    output csvfd_pkg::parse_state_t state_next,
    output csvfd_pkg::result_t      result
);

    logic on_target;
    logic is_nl;
    logic is_sep;
    logic is_quote;

    assign is_nl    = (in_byte == csvfd_pkg::BYTE_NL);
    assign is_quote = (in_byte == csvfd_pkg::BYTE_QUOTE);
    assign is_sep   = (in_byte == cfg.in_separator);
    assign on_target =
        (csvfd_pkg::CMP_BITS'(state.line_number) == csvfd_pkg::CMP_BITS'(cfg.target_line));

    always_comb
    begin
        state_next = state;
        result     = '{count: 2'd0, head: in_byte, tail: in_byte};

        case (cfg.mode)
            csvfd_pkg::MODE_DELETE:
            begin
                if (!on_target)
                    result.count = 2'd1;
            end
            csvfd_pkg::MODE_KEEP:
            begin
                if (!state.keep_done && on_target)
                begin
                    result.count = 2'd1;
                    if (is_nl)
                        state_next.keep_done = 1'b1;
                end
            end
            default:
            begin
                if (is_nl)
                begin
                    result = '{count: 2'd2, head: cfg.out_separator, tail: csvfd_pkg::BYTE_NL};
                end
                else
                begin
                    case (state.phase)
                        csvfd_pkg::PH_START:
                        begin
                            if (is_quote)
                                state_next.phase = csvfd_pkg::PH_QUOTED;
                            else if (is_sep)
                                result = '{count: 2'd1, head: cfg.out_separator, tail: in_byte};
                            else
                            begin
                                result.count     = 2'd1;
                                state_next.phase = csvfd_pkg::PH_PLAIN;
                            end
                        end
                        csvfd_pkg::PH_PLAIN:
                        begin
                            if (is_sep)
                            begin
                                result = '{count: 2'd1, head: cfg.out_separator, tail: in_byte};
                                state_next.phase = csvfd_pkg::PH_START;
                            end
                            else
                                result.count = 2'd1;
                        end
                        csvfd_pkg::PH_QUOTED:
                        begin
                            if (is_quote)
                                state_next.phase = csvfd_pkg::PH_CLOSED;
                            else
                                result.count = 2'd1;
                        end
                        default:
                        begin
                            // closing quote seen: the field ends here in any case
                            result.head = cfg.out_separator;
                            if (is_sep)
                            begin
                                result.count     = 2'd1;
                                state_next.phase = csvfd_pkg::PH_START;
                            end
                            else if (is_quote)
                            begin
                                result.count     = 2'd1;
                                state_next.phase = csvfd_pkg::PH_QUOTED;
                            end
                            else
                            begin
                                result.count     = 2'd2;
                                state_next.phase = csvfd_pkg::PH_PLAIN;
                            end
                        end
                    endcase
                end
            end
        endcase

        // newline ends line and field in every mode
        if (is_nl)
        begin
            state_next.phase = csvfd_pkg::PH_START;
            if (state.line_number != {csvfd_pkg::LINE_NUMBER_BITS{1'b1}})
                state_next.line_number = state.line_number + 1'b1;
        end
    end

endmodule

// ----- rtl/csvfd_out_buf.sv -----
module csvfd_out_buf (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                load,
    input  csvfd_pkg::result_t  result,
    output logic                free,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [7:0]          m_tdata,   // out_byte[7:0]
    output logic                m_tlast    // run_last
);

    logic [1:0] count_reg;
    logic [1:0] count_next;
    logic [7:0] head_reg;
    logic [7:0] head_next;
    logic [7:0] tail_reg;
    logic [7:0] tail_next;
    logic       take;

    assign m_tvalid = (count_reg != 2'd0);
    assign m_tdata  = head_reg;
    assign m_tlast  = (count_reg == 2'd1);
    assign take     = m_tvalid && m_tready;
    // can refill when empty or when the final word goes out now
    assign free     = (count_reg == 2'd0) || (m_tlast && m_tready);

    always_comb
    begin
        count_next = count_reg;
        head_next  = head_reg;
        tail_next  = tail_reg;
        if (load)
        begin
            count_next = result.count;
            head_next  = result.head;
            tail_next  = result.tail;
        end
        else if (take)
        begin
            count_next = count_reg - 2'd1;
            head_next  = tail_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= 2'd0;
        else
            count_reg <= count_next;
    end

    always_ff @(posedge clk)
    begin
        head_reg <= head_next;
        tail_reg <= tail_next;
    end

endmodule

// ----- rtl/csv_field_delimiter_converter.sv -----
// CSV field converter and line filter. One text word in, zero to two words out.
// Convert mode splits lines at in_separator, drops double quotes around quoted
// fields, writes out_separator after every field (empty ones too) and ends each
// line with a newline; delete mode drops the target line; keep mode passes only
// the target line and then nothing more. Rate: one input word per cycle when
// each word yields at most one output word and the output is ready; a word that
// yields two (a newline in convert mode, or text right after a closing quote)
// holds the input back while its second word goes out, since the output port
// moves one word per cycle. Pipeline: an input register, then the parser step,
// then a two-word result register; an accepted word is held in the input register
// until the result register is free, and its result is then loaded there. Configuration is written
// through cfg_we/cfg_index/cfg_data and should change only while idle.
`include "csv_field_delimiter_converter_assert.svh"

module csv_field_delimiter_converter (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // in_byte[7:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,    // out_byte[7:0]
    output logic        m_tlast,    // run_last
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    csvfd_pkg::cfg_t         cfg_reg;
    csvfd_pkg::parse_state_t state_reg;
    csvfd_pkg::parse_state_t state_next;
    csvfd_pkg::result_t      result;

    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       free;
    logic       move;

    // input word moves through the parser when the result register can take it
    assign move     = in_valid_reg && free;
    assign s_tready = !in_valid_reg || move;

    // config registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.mode          <= csvfd_pkg::MODE_CONVERT;
            cfg_reg.target_line   <= '0;
            cfg_reg.out_separator <= csvfd_pkg::OUT_SEPARATOR_RESET;
            cfg_reg.in_separator  <= csvfd_pkg::IN_SEPARATOR_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                csvfd_pkg::REG_MODE:          cfg_reg.mode          <= cfg_data[1:0];
                csvfd_pkg::REG_TARGET_LINE:   cfg_reg.target_line   <= cfg_data;
                csvfd_pkg::REG_OUT_SEPARATOR: cfg_reg.out_separator <= cfg_data[7:0];
                csvfd_pkg::REG_IN_SEPARATOR:  cfg_reg.in_separator  <= cfg_data[7:0];
                default:                      cfg_reg               <= cfg_reg;
            endcase
        end
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_tready)
            in_valid_reg <= s_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
            in_byte_reg <= s_tdata;
    end

    // parser state advances only when a word is processed
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.phase       <= csvfd_pkg::PH_START;
            state_reg.line_number <= csvfd_pkg::LINE_NUMBER_BITS'(1);
            state_reg.keep_done   <= 1'b0;
        end
        else if (move)
            state_reg <= state_next;
    end

    csvfd_step u_step (
        .in_byte    (in_byte_reg),
        .cfg        (cfg_reg),
        .state      (state_reg),
        .state_next (state_next),
        .result     (result)
    );

    csvfd_out_buf u_out_buf (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (move),
        .result   (result),
        .free     (free),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    // keep_done only sets on a processed newline in keep mode
    `CSVFD_ASSERT(a_keep_done_cause, !$rose(state_reg.keep_done) || $past(move && cfg_reg.mode == csvfd_pkg::MODE_KEEP && in_byte_reg == csvfd_pkg::BYTE_NL), "keep_done set without newline in keep mode")
    // line counter never goes backwards
    `CSVFD_ASSERT(a_line_monotonic, state_reg.line_number >= $past(state_reg.line_number), "line number decreased")
    // newline returns the field parser to field start
    `CSVFD_ASSERT_NEXT(a_nl_field_start, move && in_byte_reg == csvfd_pkg::BYTE_NL, state_reg.phase == csvfd_pkg::PH_START, "phase not reset after newline")

endmodule
